@@ hw/rtl/pltab_pkg.sv @@
// ============================================================================
// pltab_pkg: shared types and codes for the positional list table
// Request and result item layouts, request and status codes, and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package pltab_pkg;

    // Default number of list entries.
    localparam int CAPACITY_DEFAULT = 32;

    // Width of the entry count field of a result item.
    localparam int COUNT_W = 7;

    // Request codes.
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_INS_AT    = 3'd2;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
    localparam logic [2:0] REQ_DEL_AT    = 3'd5;
    localparam logic [2:0] REQ_READ_ALL  = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // One request item.
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic signed [31:0] entry_value;
        logic               last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic exec;
        logic read_step;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic read_go;
        logic read_last;
    } dp_stat_t;

endpackage

@@ hw/rtl/pltab_ctrl.sv @@
// ============================================================================
// pltab_ctrl: request sequencer
// Accepts an item, runs its execute cycle and, for a read out of a
// non-empty list, steps through one entry per cycle.
// ============================================================================
module pltab_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output pltab_pkg::ctrl_cmd_t  cmd,
    input  pltab_pkg::dp_stat_t   stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    // State and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    if (stat.read_go)
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                S_READ:
                begin
                    if (stat.read_last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;

    // Commands follow the state.
    always_comb
    begin
        cmd.load_req  = start && (state_reg == S_IDLE);
        cmd.exec      = (state_reg == S_EXEC);
        cmd.read_step = (state_reg == S_READ);
    end

    // The busy flag tracks the idle state exactly.
    a_busy_state : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy flag out of step with state");

    // An accepted item is executed in the next cycle.
    a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    // A read out only starts from an execute cycle.
    a_read_entry : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.read_step) |-> $past(cmd.exec && stat.read_go))
        else $error("read out entered without execute");

endmodule

@@ hw/rtl/pltab_dp.sv @@
// ============================================================================
// pltab_dp: list storage and result datapath
// Holds the entries as a row of cells that shift by one place on insert,
// delete and read out, the entry count, and the registered result item.
// ============================================================================
module pltab_dp #(
    parameter int CAPACITY = pltab_pkg::CAPACITY_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pltab_pkg::req_t       req,
    input  pltab_pkg::ctrl_cmd_t  cmd,
    output pltab_pkg::dp_stat_t   stat,
    output logic                  result_valid,
    output pltab_pkg::rsp_t       result
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int COUNT_W = pltab_pkg::COUNT_W;

    pltab_pkg::req_t    req_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   rd_idx_next;
    logic signed [31:0] ent_reg  [CAPACITY];
    logic signed [31:0] ent_next [CAPACITY];
    logic               out_valid_reg;
    logic               out_valid_next;
    pltab_pkg::rsp_t    out_reg;
    pltab_pkg::rsp_t    out_next;

    logic               full;
    logic               empty;
    logic               ins_bad;
    logic               del_bad;
    logic               do_ins;
    logic               do_del;
    logic               read_go;
    logic [CNT_W-1:0]   idx;
    logic [CNT_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   cnt_m1;
    logic [8:0]         pos_ext;
    logic [8:0]         cnt_ext;
    logic [1:0]         st;

    // Request decode and status checks.
    always_comb
    begin
        full    = (cnt_reg == CNT_W'(CAPACITY));
        empty   = (cnt_reg == '0);
        pos_ext = {1'b0, req_reg.position};
        cnt_ext = 9'(cnt_reg);
        ins_bad = (req_reg.position == 8'd0) || (pos_ext > cnt_ext + 9'd1);
        del_bad = (req_reg.position == 8'd0) || (pos_ext > cnt_ext);
        pos_m1  = CNT_W'(req_reg.position - 8'd1);
        cnt_m1  = cnt_reg - CNT_W'(1);
        do_ins  = 1'b0;
        do_del  = 1'b0;
        idx     = '0;
        st      = pltab_pkg::ST_OK;
        case (req_reg.req_type)
            pltab_pkg::REQ_INS_FRONT:
            begin
                if (full) st = pltab_pkg::ST_FULL;
                else      do_ins = 1'b1;
            end
            pltab_pkg::REQ_INS_BACK:
            begin
                idx = cnt_reg;
                if (full) st = pltab_pkg::ST_FULL;
                else      do_ins = 1'b1;
            end
            pltab_pkg::REQ_INS_AT:
            begin
                idx = pos_m1;
                if (ins_bad)   st = pltab_pkg::ST_BADPOS;
                else if (full) st = pltab_pkg::ST_FULL;
                else           do_ins = 1'b1;
            end
            pltab_pkg::REQ_DEL_FRONT:
            begin
                if (empty) st = pltab_pkg::ST_EMPTY;
                else       do_del = 1'b1;
            end
            pltab_pkg::REQ_DEL_BACK:
            begin
                idx = cnt_m1;
                if (empty) st = pltab_pkg::ST_EMPTY;
                else       do_del = 1'b1;
            end
            pltab_pkg::REQ_DEL_AT:
            begin
                idx = pos_m1;
                if (empty)        st = pltab_pkg::ST_EMPTY;
                else if (del_bad) st = pltab_pkg::ST_BADPOS;
                else              do_del = 1'b1;
            end
            pltab_pkg::REQ_READ_ALL:
            begin
                if (empty) st = pltab_pkg::ST_EMPTY;
            end
            default:
            begin
                st = pltab_pkg::ST_OK;
            end
        endcase
        read_go = (req_reg.req_type == pltab_pkg::REQ_READ_ALL) && !empty;
    end

    assign stat.read_go   = read_go;
    assign stat.read_last = (rd_idx_reg == cnt_m1);

    // Count and read out index.
    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.exec)
        begin
            rd_idx_next = '0;
            if (do_ins)      cnt_next = cnt_reg + CNT_W'(1);
            else if (do_del) cnt_next = cnt_m1;
        end
        else if (cmd.read_step)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    // Each cell takes its neighbor, the new value, or the head on wrap.
    // A read out rotates the live entries, so after a full pass the list
    // is back in its original order.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ent_next[i] = ent_reg[i];
            if (cmd.exec && do_ins)
            begin
                if (CNT_W'(i) == idx)
                    ent_next[i] = req_reg.value;
                else if (CNT_W'(i) > idx)
                    ent_next[i] = ent_reg[(i == 0) ? 0 : i - 1];
            end
            else if (cmd.exec && do_del)
            begin
                if ((CNT_W'(i) >= idx) && (i < CAPACITY - 1))
                    ent_next[i] = ent_reg[(i == CAPACITY - 1) ? i : i + 1];
            end
            else if (cmd.read_step)
            begin
                if (CNT_W'(i) == cnt_m1)
                    ent_next[i] = ent_reg[0];
                else if (CNT_W'(i) < cnt_m1)
                    ent_next[i] = ent_reg[(i == CAPACITY - 1) ? i : i + 1];
            end
        end
    end

    // Result item.
    always_comb
    begin
        out_valid_next       = (cmd.exec && !read_go) || cmd.read_step;
        out_next.status      = st;
        out_next.entry_count = COUNT_W'(cnt_next);
        out_next.entry_value = '0;
        out_next.last        = 1'b1;
        if (cmd.read_step)
        begin
            out_next.status      = pltab_pkg::ST_OK;
            out_next.entry_count = COUNT_W'(cnt_reg);
            out_next.entry_value = ent_reg[0];
            out_next.last        = stat.read_last;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= req;
        if (out_valid_next)
            out_reg <= out_next;
        for (int i = 0; i < CAPACITY; i++)
            ent_reg[i] <= ent_next[i];
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The count never exceeds the capacity.
    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A read out only runs over a non-empty list.
    a_read_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_step |-> (cnt_reg != '0))
        else $error("read out of an empty list");

    // The count holds while a read out runs.
    a_read_cnt : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_step |=> $stable(cnt_reg))
        else $error("count changed during read out");

    // A final result ends the request: no read step follows it.
    a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last) |-> !cmd.read_step)
        else $error("read out continues past the final result");

endmodule

@@ hw/rtl/positional_list_table_core.sv @@
// ============================================================================
// positional_list_table_core: ordered list of signed 32-bit values
// Insert and delete at front, back or a 1-based position, and read out.
// ============================================================================
// A request is taken when start is high and busy is low. For inserts,
// deletes and a read out of an empty list, the item is latched, the list
// shifts by one place in the execute cycle if an insert or delete succeeds,
// and the single result appears with result_valid in the cycle after, while
// busy is already low so the next item can be taken in that same cycle. A
// read out of a list of N entries runs through the accept cycle, the execute
// cycle and a read step for each entry, and gives N results on consecutive
// cycles, one per cycle from the head of the shifting cell row, the last one
// marked. Results are shown for one cycle only and cannot be held off, so the
// receiver must take every cycle in which result_valid is high.
// ============================================================================
module positional_list_table_core #(
    parameter int CAPACITY = pltab_pkg::CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pltab_pkg::req_t   req,
    output logic              result_valid,
    output pltab_pkg::rsp_t   result
);

    pltab_pkg::ctrl_cmd_t cmd;
    pltab_pkg::dp_stat_t  stat;

    // Request sequencer.
    pltab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // List storage and result path.
    pltab_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ test/tb_top.sv @@
// ============================================================================
// tb_top: testbench for the positional list table core
// Drives insert, delete and read out requests through the start/busy
// handshake and checks every result item against a predictor of the list
// that runs beside the block. A directed table covers the empty, full and
// bad-position cases and the extreme values, then random requests drift
// the list between empty and full with random gaps on the request side.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = pltab_pkg::CAPACITY_DEFAULT;
    // Request code that the block ignores.
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 105;
    // Cycles with no item taken and no result seen before the run is stopped.
    localparam int IDLE_LIMIT = 1000;
    // Cycles to watch for stray results once nothing is expected.
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    // One row of the directed stimulus table.
    typedef struct {
        logic [2:0]  code;
        logic [31:0] value;
        logic [7:0]  position;
        int          reps;
        bit          typed;
        logic [1:0]  status;
        int          count;
    } step_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    pltab_pkg::req_t  req = '0;
    logic  result_valid;
    pltab_pkg::rsp_t  result;

    // Typed-in expectation that travels with the current directed item.
    logic  typed_on = 1'b0;
    pltab_pkg::rsp_t  typed_rsp = '0;

    // Predicted list contents and the results still to come.
    logic signed [31:0] list_mem [CAPACITY];
    int unsigned        list_len = 0;
    pltab_pkg::rsp_t    pending_rsp [$];
    pltab_pkg::rsp_t    head_rsp;

    int    mismatch_count = 0;
    int    quiet_cycles = 0;
    step_t steps [$];

    positional_list_table_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        #2 clk = ~clk;
    end

    // Build one result item from its fields.
    function automatic pltab_pkg::rsp_t make_rsp(logic [1:0] st, int unsigned cnt,
                                                 logic [31:0] val, logic lst);
        pltab_pkg::rsp_t r;
        r.status      = st;
        r.entry_count = pltab_pkg::COUNT_W'(cnt);
        r.entry_value = val;
        r.last        = lst;
        return r;
    endfunction

    // Insert a value so that it lands at 0-based index idx.
    task automatic list_insert(int unsigned idx, logic [31:0] val);
        for (int unsigned i = list_len; i > idx; i--)
            list_mem[i] = list_mem[i - 1];
        list_mem[idx] = val;
        list_len++;
    endtask

    // Remove the entry at 0-based index idx and close the gap.
    task automatic list_remove(int unsigned idx);
        for (int unsigned i = idx; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i + 1];
        list_len--;
    endtask

    // Apply one request to the predicted list and queue the results it gives.
    task automatic apply_request(pltab_pkg::req_t r);
        logic [1:0] st;
        st = pltab_pkg::ST_OK;
        case (r.req_type)
            pltab_pkg::REQ_INS_FRONT, pltab_pkg::REQ_INS_BACK:
            begin
                if (list_len >= CAPACITY)
                    st = pltab_pkg::ST_FULL;
                else
                    list_insert((r.req_type == pltab_pkg::REQ_INS_FRONT) ? 0 : list_len,
                                r.value);
            end
            pltab_pkg::REQ_INS_AT:
            begin
                // The position is checked before the full condition.
                if (r.position < 1 || r.position > list_len + 1)
                    st = pltab_pkg::ST_BADPOS;
                else if (list_len >= CAPACITY)
                    st = pltab_pkg::ST_FULL;
                else
                    list_insert(r.position - 1, r.value);
            end
            pltab_pkg::REQ_DEL_FRONT, pltab_pkg::REQ_DEL_BACK:
            begin
                if (list_len == 0)
                    st = pltab_pkg::ST_EMPTY;
                else
                    list_remove((r.req_type == pltab_pkg::REQ_DEL_FRONT) ? 0 : list_len - 1);
            end
            pltab_pkg::REQ_DEL_AT:
            begin
                if (list_len == 0)
                    st = pltab_pkg::ST_EMPTY;
                else if (r.position < 1 || r.position > list_len)
                    st = pltab_pkg::ST_BADPOS;
                else
                    list_remove(r.position - 1);
            end
            pltab_pkg::REQ_READ_ALL:
            begin
                if (list_len == 0)
                    st = pltab_pkg::ST_EMPTY;
                else
                begin
                    for (int unsigned i = 0; i < list_len; i++)
                        pending_rsp.push_back(make_rsp(pltab_pkg::ST_OK, list_len,
                                                       list_mem[i], i + 1 == list_len));
                    return;
                end
            end
            default:
            begin
                // The unused code changes nothing and reports ok.
            end
        endcase
        pending_rsp.push_back(make_rsp(st, list_len, '0, 1'b1));
    endtask

    // Check results and record accepted items, one edge at a time.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Results first: an item taken at this edge has no result yet.
            if (result_valid)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result: status %0d count %0d value %0d last %0d",
                             $time, result.status, result.entry_count,
                             result.entry_value, result.last);
                end
                else
                begin
                    head_rsp = pending_rsp.pop_front();
                    if (result !== head_rsp)
                    begin
                        mismatch_count++;
                        $display("%0t: mismatch: expected status %0d count %0d value %0d last %0d",
                                 $time, head_rsp.status, head_rsp.entry_count,
                                 head_rsp.entry_value, head_rsp.last);
                        $display("%0t:           actual status %0d count %0d value %0d last %0d",
                                 $time, result.status, result.entry_count,
                                 result.entry_value, result.last);
                    end
                end
            end

            // A directed row with a typed-in result replaces the prediction.
            if (start && !busy)
            begin
                apply_request(req);
                if (typed_on)
                begin
                    void'(pending_rsp.pop_back());
                    pending_rsp.push_back(typed_rsp);
                end
            end

            // Watchdog on handshake activity.
            if (result_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Add one row to the directed table.
    task automatic add_step(logic [2:0] code, logic [31:0] value, logic [7:0] position,
                            int reps, bit typed, logic [1:0] st, int cnt);
        step_t s;
        s.code     = code;
        s.value    = value;
        s.position = position;
        s.reps     = reps;
        s.typed    = typed;
        s.status   = st;
        s.count    = cnt;
        steps.push_back(s);
    endtask

    // Offer one item, with an optional gap first, and wait until it is taken.
    task automatic send_item(pltab_pkg::req_t item, bit typed, pltab_pkg::rsp_t exp_rsp,
                             bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start     <= 1'b1;
        req       <= item;
        typed_on  <= typed;
        typed_rsp <= exp_rsp;
        do
            @(posedge clk);
        while (!(start && !busy));
    endtask

    // Pick a random request; growing favors inserts, shrinking deletes.
    function automatic pltab_pkg::req_t pick_request(bit growing);
        pltab_pkg::req_t r;
        int unsigned     roll;
        int unsigned     kind;
        roll       = $urandom_range(0, 99);
        kind       = $urandom_range(0, 2);
        r.value    = $urandom;
        r.position = 8'($urandom_range(1, list_len + 1));
        if (roll < 10)
            r.value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (roll < 60)
            r.req_type = growing ? 3'(pltab_pkg::REQ_INS_FRONT + kind)
                                 : 3'(pltab_pkg::REQ_DEL_FRONT + kind);
        else if (roll < 75)
            r.req_type = growing ? 3'(pltab_pkg::REQ_DEL_FRONT + kind)
                                 : 3'(pltab_pkg::REQ_INS_FRONT + kind);
        else if (roll < 85)
            r.req_type = pltab_pkg::REQ_READ_ALL;
        else if (roll < 90)
            r.req_type = REQ_UNUSED;
        else
        begin
            // Positions anywhere in the field, mostly out of range.
            r.req_type = (roll < 95) ? pltab_pkg::REQ_INS_AT : pltab_pkg::REQ_DEL_AT;
            r.position = 8'($urandom_range(0, 255));
        end
        if (r.req_type == pltab_pkg::REQ_DEL_AT && roll < 90)
            r.position = 8'($urandom_range(1, (list_len == 0) ? 1 : list_len));
        return r;
    endfunction

    // Stimulus: reset, directed table, random drift, then drain.
    initial
    begin
        pltab_pkg::req_t item;
        bit              growing;

        add_step(pltab_pkg::REQ_READ_ALL,  32'h0,         8'd0,   1, 1,
                 pltab_pkg::ST_EMPTY,  0);
        add_step(pltab_pkg::REQ_DEL_FRONT, 32'h0,         8'd0,   1, 1,
                 pltab_pkg::ST_EMPTY,  0);
        add_step(pltab_pkg::REQ_DEL_BACK,  32'h0,         8'd0,   1, 1,
                 pltab_pkg::ST_EMPTY,  0);
        add_step(pltab_pkg::REQ_DEL_AT,    32'h0,         8'd1,   1, 1,
                 pltab_pkg::ST_EMPTY,  0);
        add_step(pltab_pkg::REQ_DEL_AT,    32'h0,         8'd255, 1, 1,
                 pltab_pkg::ST_EMPTY,  0);
        add_step(pltab_pkg::REQ_INS_AT,    32'h1,         8'd0,   1, 1,
                 pltab_pkg::ST_BADPOS, 0);
        add_step(pltab_pkg::REQ_INS_AT,    32'h1,         8'd2,   1, 1,
                 pltab_pkg::ST_BADPOS, 0);
        add_step(pltab_pkg::REQ_INS_AT,    32'h8000_0000, 8'd1,   1, 1,
                 pltab_pkg::ST_OK,     1);
        add_step(pltab_pkg::REQ_INS_FRONT, 32'h7FFF_FFFF, 8'd0,   1, 1,
                 pltab_pkg::ST_OK,     2);
        add_step(pltab_pkg::REQ_INS_BACK,  32'hFFFF_FFFF, 8'd0,   1, 1,
                 pltab_pkg::ST_OK,     3);
        add_step(pltab_pkg::REQ_INS_AT,    32'h0,         8'd4,   1, 1,
                 pltab_pkg::ST_OK,     4);
        add_step(pltab_pkg::REQ_INS_AT,    32'h5555_5555, 8'd2,   1, 1,
                 pltab_pkg::ST_OK,     5);
        add_step(pltab_pkg::REQ_READ_ALL,  32'h0,         8'd0,   1, 0,
                 pltab_pkg::ST_OK,     0);
        add_step(pltab_pkg::REQ_DEL_AT,    32'h0,         8'd0,   1, 1,
                 pltab_pkg::ST_BADPOS, 5);
        add_step(pltab_pkg::REQ_DEL_AT,    32'h0,         8'd6,   1, 1,
                 pltab_pkg::ST_BADPOS, 5);
        add_step(pltab_pkg::REQ_DEL_AT,    32'h0,         8'd3,   1, 1,
                 pltab_pkg::ST_OK,     4);
        add_step(pltab_pkg::REQ_READ_ALL,  32'h0,         8'd0,   1, 0,
                 pltab_pkg::ST_OK,     0);
        add_step(pltab_pkg::REQ_DEL_FRONT, 32'h0,         8'd0,   1, 1,
                 pltab_pkg::ST_OK,     3);
        add_step(pltab_pkg::REQ_DEL_BACK,  32'h0,         8'd0,   1, 1,
                 pltab_pkg::ST_OK,     2);
        add_step(REQ_UNUSED,               32'hFFFF_FFFF, 8'd255, 1, 1,
                 pltab_pkg::ST_OK,     2);
        // Fill the list to capacity with random values.
        add_step(pltab_pkg::REQ_INS_BACK,  32'h0,         8'd0,   CAPACITY - 2, 0,
                 pltab_pkg::ST_OK, 0);
        add_step(pltab_pkg::REQ_INS_FRONT, 32'h1234_5678, 8'd0,   1, 1,
                 pltab_pkg::ST_FULL,   CAPACITY);
        add_step(pltab_pkg::REQ_INS_AT,    32'h1,         8'(CAPACITY + 2), 1, 1,
                 pltab_pkg::ST_BADPOS, CAPACITY);
        add_step(pltab_pkg::REQ_INS_AT,    32'h1,         8'(CAPACITY + 1), 1, 1,
                 pltab_pkg::ST_FULL,   CAPACITY);
        add_step(pltab_pkg::REQ_READ_ALL,  32'h0,         8'd0,   1, 0,
                 pltab_pkg::ST_OK,     0);
        add_step(pltab_pkg::REQ_DEL_AT,    32'h0,         8'(CAPACITY), 1, 1,
                 pltab_pkg::ST_OK, CAPACITY - 1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[n])
        begin
            for (int k = 0; k < steps[n].reps; k++)
            begin
                item.req_type = steps[n].code;
                item.value    = (steps[n].reps > 1) ? $urandom : steps[n].value;
                item.position = steps[n].position;
                send_item(item, steps[n].typed,
                          make_rsp(steps[n].status, steps[n].count, '0, 1'b1), 1'b1);
            end
        end

        // Random drift between empty and full; a middle stretch has no gaps.
        growing = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (list_len >= CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (list_len == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            item = pick_request(growing);
            send_item(item, 1'b0, '0, !(n >= 60 && n < 100));
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pltab_pkg.sv
hw/rtl/pltab_ctrl.sv
hw/rtl/pltab_dp.sv
hw/rtl/positional_list_table_core.sv
test/tb_top.sv
